// ===== rtl/vigenere_alnum_stream_cipher_defines.svh =====
// Assertion macros used by the cipher RTL.
`ifndef VIGENERE_ALNUM_STREAM_CIPHER_DEFINES_SVH
`define VIGENERE_ALNUM_STREAM_CIPHER_DEFINES_SVH

// Property that must hold on every clock out of reset; expects clk and rst_n in scope.
`define VAC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");

// Antecedent in one cycle implies consequent in the next.
`define VAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/vac_pkg.sv =====
// Shared types, constants and a helper function for the alnum cipher.
package vac_pkg;

  localparam int VAC_MAX_KEY_BYTES = 16;

  localparam logic [7:0] SHIFT_MOD  = 8'd130;
  localparam logic [7:0] DIGIT_MOD  = 8'd10;
  localparam logic [7:0] ALPHA_MOD  = 8'd26;
  localparam logic [7:0] CASE_GAP   = 8'd32;  // 'a' - 'A'
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UZ      = 8'h5a;
  localparam logic [7:0] CH_LA      = CH_UA + CASE_GAP;
  localparam logic [7:0] CH_LZ      = CH_UZ + CASE_GAP;
  localparam logic [5:0] ALPHA_BASE = 6'd10;

  typedef enum logic [1:0] {
    MODE_ADD     = 2'd0,
    MODE_SUB     = 2'd1,
    MODE_ADD_CUM = 2'd2,
    MODE_SUB_CUM = 2'd3
  } mode_t;

  typedef enum logic [7:0] {
    CFG_MODE     = 8'd0,
    CFG_KEY_LEN  = 8'd1,
    CFG_KEY_LOW  = 8'd2,
    CFG_KEY_HIGH = 8'd3
  } cfg_idx_t;

  // Key byte to shift value, 0..35.
  function automatic logic [5:0] shift_of(input logic [7:0] b);
    logic [7:0] t;
    t = 8'd0;
    if (b >= CH_0 && b <= CH_9) begin
      t = b - CH_0;
    end else if (b >= CH_UA && b <= CH_UZ) begin
      t = b - CH_UA + 8'(ALPHA_BASE);
    end else if (b >= CH_LA && b <= CH_LZ) begin
      t = b - CH_LA + 8'(ALPHA_BASE);
    end
    return t[5:0];
  endfunction

endpackage

// ===== rtl/vac_shift_gen.sv =====
// Key position / running shift state and per-byte shift distance.
module vac_shift_gen
  import vac_pkg::*;
#(
  parameter int MAX_KEY_BYTES = VAC_MAX_KEY_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mode_t       mode,
  input  logic [4:0]  key_length,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  logic        step,
  input  logic        last,
  output logic [7:0]  shift_amt
);

  `include "vigenere_alnum_stream_cipher_defines.svh"

  localparam logic [4:0] MaxLen = 5'(MAX_KEY_BYTES);

  logic [3:0]   key_position_r, key_position_nxt;
  logic [7:0]   running_shift_r, running_shift_nxt;
  logic [127:0] key_all;
  logic [7:0]   kbyte;
  logic [5:0]   v;
  logic [7:0]   run_sum;
  logic [4:0]   len_use;
  logic [4:0]   pos_inc;

  always_comb begin
    key_all = {key_high, key_low};
    kbyte   = key_all[{key_position_r, 3'b000} +: 8];
    v       = shift_of(kbyte);
    run_sum = running_shift_r + 8'(v);
    if (run_sum >= SHIFT_MOD) begin
      run_sum = run_sum - SHIFT_MOD;
    end

    running_shift_nxt = running_shift_r;
    unique case (mode)
      MODE_ADD: shift_amt = 8'(v);
      MODE_SUB: shift_amt = (v == 6'd0) ? 8'd0 : SHIFT_MOD - 8'(v);
      MODE_ADD_CUM: begin
        shift_amt         = run_sum;
        running_shift_nxt = run_sum;
      end
      MODE_SUB_CUM: begin
        shift_amt         = (run_sum == 8'd0) ? 8'd0 : SHIFT_MOD - run_sum;
        running_shift_nxt = run_sum;
      end
      default: shift_amt = 8'(v);
    endcase

    if (key_length == 5'd0) begin
      len_use = 5'd1;
    end else if (key_length > MaxLen) begin
      len_use = MaxLen;
    end else begin
      len_use = key_length;
    end
    pos_inc          = {1'b0, key_position_r} + 5'd1;
    key_position_nxt = (pos_inc >= len_use) ? 4'd0 : pos_inc[3:0];

    if (last) begin
      key_position_nxt  = 4'd0;
      running_shift_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_position_r  <= 4'd0;
      running_shift_r <= 8'd0;
    end else if (step) begin
      key_position_r  <= key_position_nxt;
      running_shift_r <= running_shift_nxt;
    end
  end

  `VAC_ASSERT_ALWAYS(a_run_in_range, running_shift_r < SHIFT_MOD)
  `VAC_ASSERT_NEXT(a_last_restarts, step && last, key_position_r == 4'd0 && running_shift_r == 8'd0)
  `VAC_ASSERT_NEXT(a_plain_keeps_run, step && !last && !mode[1], $stable(running_shift_r))

endmodule

// ===== rtl/vac_rotate.sv =====
// Rotates digits mod 10 and letters mod 26 by an upward distance.
module vac_rotate
  import vac_pkg::*;
(
  input  logic [7:0] char_i,
  input  logic [7:0] shift_amt,
  output logic [7:0] char_o
);

  // floor(x/10) = (x*205)>>11 and floor(x/26) = (x*79)>>11 for x below 160
  localparam logic [14:0] DigRecip = 15'd205;
  localparam logic [13:0] AlpRecip = 14'd79;

  logic        is_dig, is_up, is_lo;
  logic [7:0]  base;
  logic [7:0]  x;
  logic [14:0] dig_p;
  logic [13:0] alp_p;
  logic [7:0]  dig_r, alp_r;

  always_comb begin
    is_dig = (char_i >= CH_0)  && (char_i <= CH_9);
    is_up  = (char_i >= CH_UA) && (char_i <= CH_UZ);
    is_lo  = (char_i >= CH_LA) && (char_i <= CH_LZ);
    base   = is_dig ? CH_0 : (is_up ? CH_UA : CH_LA);
    x      = char_i - base + shift_amt;
    dig_p  = 15'(x) * DigRecip;
    alp_p  = 14'(x) * AlpRecip;
    dig_r  = x - 8'(dig_p[14:11]) * DIGIT_MOD;
    alp_r  = x - 8'(alp_p[13:11]) * ALPHA_MOD;
    if (is_dig) begin
      char_o = base + dig_r;
    end else if (is_up || is_lo) begin
      char_o = base + alp_r;
    end else begin
      char_o = char_i;
    end
  end

endmodule

// ===== rtl/vigenere_alnum_stream_cipher.sv =====
// Top level of the digit/letter Vigenere stream cipher.
// Usage:
//   Input channel (in_valid/in_ready, in_char, in_last): one message byte per
//   request; in_last marks the end of a message, after which the key position
//   and running shift restart.
//   Output channel (out_valid/out_ready, out_char, out_last): one ciphered
//   byte per input request, in order, with in_last copied through.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 mode,
//   1 key length, 2 key bytes 0..7, 3 key bytes 8..15; other indexes ignored.
//   cfg_ready is always high; write only while the stream is idle.
// Timing: a request passes through the input register, then the result
//   register. One byte per clock sustained while out_ready stays high, set by
//   the key state update that feeds back on itself at each step.
// Reset (rst_n low, synchronous): both pipeline slots empty, mode add, key
//   length 1, key all zero, key position and running shift zero.
// Stall: with out_ready low the result register holds; one more request is
//   taken into the input register, then in_ready drops until out_ready.
module vigenere_alnum_stream_cipher
  import vac_pkg::*;
#(
  parameter int MAX_KEY_BYTES = VAC_MAX_KEY_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  // input requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        in_last,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // config registers
  mode_t       mode_r;
  logic [4:0]  key_length_r;
  logic [63:0] key_low_r;
  logic [63:0] key_high_r;

  // input register
  logic        s1_vld_r;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;

  // result register
  logic        out_vld_r;
  logic [7:0]  out_char_r;
  logic        out_last_r;

  logic        s1_adv;   // input slot hands its byte to the result slot
  logic        step;
  logic [7:0]  shift_amt;
  logic [7:0]  cipher_char;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_vld_r || out_ready;
  assign in_ready  = !s1_vld_r || s1_adv;
  assign step      = s1_vld_r && s1_adv;

  assign out_valid = out_vld_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_ADD;
      key_length_r <= 5'd1;
      key_low_r    <= 64'd0;
      key_high_r   <= 64'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:     mode_r       <= mode_t'(cfg_data[1:0]);
        CFG_KEY_LEN:  key_length_r <= cfg_data[4:0];
        CFG_KEY_LOW:  key_low_r    <= cfg_data;
        CFG_KEY_HIGH: key_high_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (s1_adv) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  // payloads, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char;
      s1_last_r <= in_last;
    end
    if (step) begin
      out_char_r <= cipher_char;
      out_last_r <= s1_last_r;
    end
  end

  vac_shift_gen #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_shift_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .key_length (key_length_r),
    .key_low    (key_low_r),
    .key_high   (key_high_r),
    .step       (step),
    .last       (s1_last_r),
    .shift_amt  (shift_amt)
  );

  vac_rotate u_rotate (
    .char_i    (s1_char_r),
    .shift_amt (shift_amt),
    .char_o    (cipher_char)
  );

endmodule
